>>> design/nfa_pkg.sv
// Shared types and codes for the NFA set simulator.
// Holds the request/response beat structs, request codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package nfa_pkg;

    // Default sizes of the automaton.
    localparam int NUM_STATES_DEF  = 32;
    localparam int NUM_SYMBOLS_DEF = 128;

    // Fixed field widths of a request beat.
    localparam int REQ_TYPE_W = 3;
    localparam int STATE_FW   = 5;
    localparam int SYMBOL_FW  = 7;

    // Request codes.
    localparam logic [REQ_TYPE_W-1:0] REQ_ADD_TRANS   = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_ADD_ALL     = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_SET_ACCEPT  = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_ADD_START   = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_SYMBOL      = 3'd4;
    localparam logic [REQ_TYPE_W-1:0] REQ_EMPTY_CHECK = 3'd5;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [STATE_FW-1:0]   src_state;
        logic [STATE_FW-1:0]   dst_state;
        logic [SYMBOL_FW-1:0]  symbol;
        logic                  accept_value;
        logic                  last_symbol;
    } req_t;

    typedef struct packed {
        logic accepted;
        logic any_active;
    } rsp_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_STEP,
        ST_DRAIN,
        ST_REPORT
    } state_t;

endpackage

>>> design/nfa_trans_mem.sv
// Transition store: one state set per (state, symbol) pair.
// Single write port and one registered read port. Uses no package items.
`timescale 1ns / 1ps

module nfa_trans_mem #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 12,
    parameter int DEPTH  = 4096
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/nfa_engine.sv
// Sequencer and set datapath of the NFA simulator.
// Walks the transition store one row per cycle and ORs rows into one accumulator.
// Depends on nfa_pkg.
`timescale 1ns / 1ps

module nfa_engine #(
    parameter int NUM_STATES  = nfa_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = nfa_pkg::NUM_SYMBOLS_DEF,
    localparam int STATE_W    = $clog2(NUM_STATES),
    localparam int SYM_W      = $clog2(NUM_SYMBOLS),
    localparam int ADDR_W     = STATE_W + SYM_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  nfa_pkg::req_t         req,
    output logic                  ready,
    output logic                  mem_we,
    output logic [ADDR_W-1:0]     mem_waddr,
    output logic [NUM_STATES-1:0] mem_wdata,
    output logic                  mem_re,
    output logic [ADDR_W-1:0]     mem_raddr,
    input  logic [NUM_STATES-1:0] mem_rdata,
    input  logic                  slot_free,
    output logic                  rpt_fire,
    output nfa_pkg::rsp_t         rpt
);

    localparam int DEPTH = NUM_STATES << SYM_W;

    nfa_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]     cnt_reg, cnt_next;
    logic [SYM_W-1:0]      end_reg, end_next;
    logic [STATE_W-1:0]    src_reg, src_next;
    logic [NUM_STATES-1:0] dst_bit_reg, dst_bit_next;
    logic [SYM_W-1:0]      sym_reg, sym_next;
    logic                  last_reg, last_next;
    logic [NUM_STATES-1:0] cur_sh_reg, cur_sh_next;
    logic                  rd_bit_reg, rd_bit_next;
    logic [NUM_STATES-1:0] acc_reg, acc_next;
    logic [NUM_STATES-1:0] active_reg, active_next;
    logic [NUM_STATES-1:0] start_reg, start_next;
    logic [NUM_STATES-1:0] accept_reg, accept_next;
    logic                  in_run_reg, in_run_next;
    logic [NUM_STATES-1:0] rpt_set_reg, rpt_set_next;

    logic                  src_ok;
    logic                  dst_ok;
    logic                  sym_ok;
    logic [SYM_W-1:0]      sym_idx;
    logic [NUM_STATES-1:0] src_bit;
    logic [NUM_STATES-1:0] dst_bit;
    logic [NUM_STATES-1:0] acc_sum;

    // Decode of the incoming request fields.
    always_comb
    begin
        src_ok  = 32'(req.src_state) < 32'(NUM_STATES);
        dst_ok  = 32'(req.dst_state) < 32'(NUM_STATES);
        sym_ok  = 32'(req.symbol) < 32'(NUM_SYMBOLS);
        sym_idx = SYM_W'(req.symbol);
        src_bit = NUM_STATES'(1) << req.src_state;
        dst_bit = NUM_STATES'(1) << req.dst_state;
    end

    // The shared unit: OR of the row read last cycle into the accumulator.
    assign acc_sum = acc_reg | (rd_bit_reg ? mem_rdata : '0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nfa_pkg::ST_CLEAR:
            begin
                if (cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = nfa_pkg::ST_IDLE;
                end
            end
            nfa_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.req_type)
                        nfa_pkg::REQ_ADD_TRANS:
                        begin
                            if (src_ok && dst_ok && sym_ok)
                            begin
                                state_next = nfa_pkg::ST_ADD_RD;
                            end
                        end
                        nfa_pkg::REQ_ADD_ALL:
                        begin
                            if (src_ok && dst_ok)
                            begin
                                state_next = nfa_pkg::ST_ADD_RD;
                            end
                        end
                        nfa_pkg::REQ_SYMBOL:
                        begin
                            if (sym_ok)
                            begin
                                state_next = nfa_pkg::ST_STEP;
                            end
                            else if (req.last_symbol)
                            begin
                                state_next = nfa_pkg::ST_REPORT;
                            end
                        end
                        nfa_pkg::REQ_EMPTY_CHECK:
                        begin
                            state_next = nfa_pkg::ST_REPORT;
                        end
                        default:
                        begin
                            state_next = nfa_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            nfa_pkg::ST_ADD_RD:
            begin
                state_next = nfa_pkg::ST_ADD_WR;
            end
            nfa_pkg::ST_ADD_WR:
            begin
                if (cnt_reg[SYM_W-1:0] == end_reg)
                begin
                    state_next = nfa_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = nfa_pkg::ST_ADD_RD;
                end
            end
            nfa_pkg::ST_STEP:
            begin
                // Stop once no higher state is left in the current set.
                if ((cur_sh_reg >> 1) == '0)
                begin
                    state_next = nfa_pkg::ST_DRAIN;
                end
            end
            nfa_pkg::ST_DRAIN:
            begin
                state_next = last_reg ? nfa_pkg::ST_REPORT : nfa_pkg::ST_IDLE;
            end
            nfa_pkg::ST_REPORT:
            begin
                if (slot_free)
                begin
                    state_next = nfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: memory port, handshake and report.
    always_comb
    begin
        ready     = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = {src_reg, cnt_reg[SYM_W-1:0]};
        mem_wdata = mem_rdata | dst_bit_reg;
        mem_raddr = {cnt_reg[STATE_W-1:0], sym_reg};
        rpt_fire  = 1'b0;
        case (state_reg)
            nfa_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = '0;
            end
            nfa_pkg::ST_IDLE:
            begin
                ready = 1'b1;
            end
            nfa_pkg::ST_ADD_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = {src_reg, cnt_reg[SYM_W-1:0]};
            end
            nfa_pkg::ST_ADD_WR:
            begin
                mem_we = 1'b1;
            end
            nfa_pkg::ST_STEP:
            begin
                mem_re = 1'b1;
            end
            nfa_pkg::ST_REPORT:
            begin
                rpt_fire = slot_free;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
        rpt.accepted   = |(rpt_set_reg & accept_reg);
        rpt.any_active = |rpt_set_reg;
    end

    // Datapath next values.
    always_comb
    begin
        cnt_next     = cnt_reg;
        end_next     = end_reg;
        src_next     = src_reg;
        dst_bit_next = dst_bit_reg;
        sym_next     = sym_reg;
        last_next    = last_reg;
        cur_sh_next  = cur_sh_reg;
        rd_bit_next  = 1'b0;
        acc_next     = acc_reg;
        active_next  = active_reg;
        start_next   = start_reg;
        accept_next  = accept_reg;
        in_run_next  = in_run_reg;
        rpt_set_next = rpt_set_reg;
        case (state_reg)
            nfa_pkg::ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            nfa_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    src_next     = STATE_W'(req.src_state);
                    dst_bit_next = dst_bit;
                    case (req.req_type)
                        nfa_pkg::REQ_ADD_TRANS:
                        begin
                            cnt_next = ADDR_W'(sym_idx);
                            end_next = sym_idx;
                        end
                        nfa_pkg::REQ_ADD_ALL:
                        begin
                            cnt_next = '0;
                            end_next = SYM_W'(NUM_SYMBOLS - 1);
                        end
                        nfa_pkg::REQ_SET_ACCEPT:
                        begin
                            if (src_ok)
                            begin
                                accept_next = req.accept_value ? (accept_reg | src_bit)
                                                               : (accept_reg & ~src_bit);
                            end
                        end
                        nfa_pkg::REQ_ADD_START:
                        begin
                            if (src_ok)
                            begin
                                start_next = start_reg | src_bit;
                            end
                        end
                        nfa_pkg::REQ_SYMBOL:
                        begin
                            // A new run begins from the start set.
                            cur_sh_next  = in_run_reg ? active_reg : start_reg;
                            sym_next     = sym_idx;
                            last_next    = req.last_symbol;
                            cnt_next     = '0;
                            acc_next     = '0;
                            in_run_next  = !req.last_symbol;
                            rpt_set_next = '0;
                            if (!sym_ok)
                            begin
                                active_next = '0;
                            end
                        end
                        nfa_pkg::REQ_EMPTY_CHECK:
                        begin
                            in_run_next  = 1'b0;
                            active_next  = start_reg;
                            rpt_set_next = start_reg;
                        end
                        default:
                        begin
                            in_run_next = in_run_reg;
                        end
                    endcase
                end
            end
            nfa_pkg::ST_ADD_WR:
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            nfa_pkg::ST_STEP:
            begin
                cnt_next    = cnt_reg + 1'b1;
                cur_sh_next = cur_sh_reg >> 1;
                rd_bit_next = cur_sh_reg[0];
                acc_next    = acc_sum;
            end
            nfa_pkg::ST_DRAIN:
            begin
                active_next  = acc_sum;
                rpt_set_next = acc_sum;
            end
            default:
            begin
                rd_bit_next = 1'b0;
            end
        endcase
    end

    // Control and set registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nfa_pkg::ST_CLEAR;
            cnt_reg    <= '0;
            rd_bit_reg <= 1'b0;
            active_reg <= '0;
            start_reg  <= NUM_STATES'(1);
            accept_reg <= '0;
            in_run_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_bit_reg <= rd_bit_next;
            active_reg <= active_next;
            start_reg  <= start_next;
            accept_reg <= accept_next;
            in_run_reg <= in_run_next;
        end
    end

    // Working registers of one request.
    always_ff @(posedge clk)
    begin
        end_reg     <= end_next;
        src_reg     <= src_next;
        dst_bit_reg <= dst_bit_next;
        sym_reg     <= sym_next;
        last_reg    <= last_next;
        cur_sh_reg  <= cur_sh_next;
        acc_reg     <= acc_next;
        rpt_set_reg <= rpt_set_next;
    end

endmodule

>>> design/nfa_set_simulator.sv
// NFA set simulator. Set accept, add start and unused codes are handled in idle; add
// transition reads and rewrites one row, add on all symbols does so for every symbol,
// and a symbol beat reads one transition row per cycle for each state up to the highest
// active one; an empty check or a last symbol waits for a free output slot. One beat is
// in work at a time. Reset initialises the control state, then clears all NUM_STATES *
// 2**ceil(log2(NUM_SYMBOLS)) RAM rows (4096 by default), with req_stall held high.
`timescale 1ns / 1ps

module nfa_set_simulator #(
    parameter int NUM_STATES  = nfa_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = nfa_pkg::NUM_SYMBOLS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  nfa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output nfa_pkg::rsp_t rsp
);

    localparam int STATE_W = $clog2(NUM_STATES);
    localparam int SYM_W   = $clog2(NUM_SYMBOLS);
    localparam int ADDR_W  = STATE_W + SYM_W;
    localparam int DEPTH   = NUM_STATES << SYM_W;

    logic                  ready;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [NUM_STATES-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [NUM_STATES-1:0] mem_rdata;
    logic                  slot_free;
    logic                  rpt_fire;
    nfa_pkg::rsp_t         rpt;

    logic                  rsp_valid_reg, rsp_valid_next;
    nfa_pkg::rsp_t         rsp_reg;

    nfa_engine #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .ready     (ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .slot_free (slot_free),
        .rpt_fire  (rpt_fire),
        .rpt       (rpt)
    );

    nfa_trans_mem #(
        .DATA_W (NUM_STATES),
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_trans_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req_stall = !ready;

    // Output register: free when empty or being taken this cycle.
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rpt_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rpt_fire)
        begin
            rsp_reg <= rpt;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> design/nfa_checker.sv
// Port-level checks for the NFA set simulator, bound to the top level.
// Depends on nfa_pkg and nfa_set_simulator.
`timescale 1ns / 1ps

module nfa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input nfa_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input nfa_pkg::rsp_t rsp
);

    // A stalled response beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // A response only appears after the block was busy producing it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response appeared without a busy cycle");

    // A beat that ends a string keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall &&
        ((req.req_type == nfa_pkg::REQ_EMPTY_CHECK) ||
         (req.req_type == nfa_pkg::REQ_SYMBOL && req.last_symbol)) |=> req_stall)
        else $error("string end accepted without a busy cycle");

    // An accepting result always has a nonempty active set.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !rsp.accepted || rsp.any_active)
        else $error("accepted reported with an empty active set");

endmodule

bind nfa_set_simulator nfa_checker u_nfa_checker (.*);

>>> dv/tb_nfa_set_simulator.sv
// Self-checking testbench for nfa_set_simulator: directed corners, output back-pressure,
// random automata with random strings, and broken runs. Depends on nfa_pkg and the DUT.
`timescale 1ns / 1ps

module tb_nfa_set_simulator;

    localparam int N_ST  = nfa_pkg::NUM_STATES_DEF;
    localparam int N_SYM = nfa_pkg::NUM_SYMBOLS_DEF;

    // Request codes the block treats as no-ops.
    localparam logic [nfa_pkg::REQ_TYPE_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [nfa_pkg::REQ_TYPE_W-1:0] REQ_SPARE_B = 3'd7;

    localparam int POOL_SIZE      = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 300;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    nfa_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    nfa_pkg::rsp_t rsp;

    // Shadow automaton.
    logic [N_ST-1:0] row_sets [0:N_ST*N_SYM-1];
    logic [N_ST-1:0] accepting;
    logic [N_ST-1:0] start_states;
    logic [N_ST-1:0] live_states;
    bit              mid_string;

    nfa_pkg::rsp_t pending_verdicts [$];

    logic [nfa_pkg::SYMBOL_FW-1:0] sym_pool [0:POOL_SIZE-1];

    int  err_count;
    int  verdict_idx;
    int  burst_left;
    int  hold_count;

    nfa_set_simulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    // One step of the set simulation: union of the rows of all live states.
    function automatic logic [N_ST-1:0] step_states(
        input logic [N_ST-1:0] cur,
        input logic [nfa_pkg::SYMBOL_FW-1:0] sym);
        logic [N_ST-1:0] nxt;
        nxt = '0;
        if (int'(sym) >= N_SYM)
        begin
            return '0;
        end
        for (int s = 0; s < N_ST; s++)
        begin
            if (cur[s])
            begin
                nxt |= row_sets[s*N_SYM + int'(sym)];
            end
        end
        return nxt;
    endfunction

    function automatic nfa_pkg::rsp_t judge_states(input logic [N_ST-1:0] states);
        nfa_pkg::rsp_t v;
        v.accepted   = |(states & accepting);
        v.any_active = |states;
        return v;
    endfunction

    // Applies one accepted request beat to the shadow automaton and queues any verdict.
    function automatic void advance_automaton(input nfa_pkg::req_t r);
        int src;
        int dst;
        int sym;
        src = int'(r.src_state);
        dst = int'(r.dst_state);
        sym = int'(r.symbol);
        case (r.req_type)
            nfa_pkg::REQ_ADD_TRANS:
            begin
                if (src < N_ST && dst < N_ST && sym < N_SYM)
                begin
                    row_sets[src*N_SYM + sym][dst] = 1'b1;
                end
            end
            nfa_pkg::REQ_ADD_ALL:
            begin
                if (src < N_ST && dst < N_ST)
                begin
                    for (int k = 0; k < N_SYM; k++)
                    begin
                        row_sets[src*N_SYM + k][dst] = 1'b1;
                    end
                end
            end
            nfa_pkg::REQ_SET_ACCEPT:
            begin
                if (src < N_ST)
                begin
                    accepting[src] = r.accept_value;
                end
            end
            nfa_pkg::REQ_ADD_START:
            begin
                if (src < N_ST)
                begin
                    start_states[src] = 1'b1;
                end
            end
            nfa_pkg::REQ_SYMBOL:
            begin
                if (!mid_string)
                begin
                    live_states = start_states;
                end
                live_states = step_states(live_states, r.symbol);
                mid_string  = 1'b1;
                if (r.last_symbol)
                begin
                    mid_string = 1'b0;
                    pending_verdicts.push_back(judge_states(live_states));
                end
            end
            nfa_pkg::REQ_EMPTY_CHECK:
            begin
                // A check in the middle of a string drops the run.
                mid_string  = 1'b0;
                live_states = start_states;
                pending_verdicts.push_back(judge_states(start_states));
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic nfa_pkg::req_t rand_fields();
        logic [$bits(nfa_pkg::req_t)-1:0] raw;
        raw = $bits(nfa_pkg::req_t)'($urandom);
        return nfa_pkg::req_t'(raw);
    endfunction

    function automatic nfa_pkg::req_t mk_req(input logic [nfa_pkg::REQ_TYPE_W-1:0] kind,
                                             input int src, input int dst, input int sym,
                                             input bit aval, input bit last);
        nfa_pkg::req_t r;
        r.req_type     = kind;
        r.src_state    = src[nfa_pkg::STATE_FW-1:0];
        r.dst_state    = dst[nfa_pkg::STATE_FW-1:0];
        r.symbol       = sym[nfa_pkg::SYMBOL_FW-1:0];
        r.accept_value = aval;
        r.last_symbol  = last;
        return r;
    endfunction

    function automatic nfa_pkg::req_t symbol_req(input bit last);
        nfa_pkg::req_t r;
        r = rand_fields();
        r.req_type    = nfa_pkg::REQ_SYMBOL;
        r.last_symbol = last;
        if ($urandom_range(0, 4) != 0)
        begin
            r.symbol = sym_pool[$urandom_range(0, POOL_SIZE-1)];
        end
        return r;
    endfunction

    // Random table load; transitions mostly land on the symbols that strings use.
    function automatic nfa_pkg::req_t load_req();
        nfa_pkg::req_t r;
        int            roll;
        r    = rand_fields();
        roll = $urandom_range(0, 99);
        if (roll < 64)
        begin
            r.req_type = nfa_pkg::REQ_ADD_TRANS;
            if ($urandom_range(0, 4) != 0)
            begin
                r.symbol = sym_pool[$urandom_range(0, POOL_SIZE-1)];
            end
        end
        else if (roll < 95)
        begin
            r.req_type     = nfa_pkg::REQ_SET_ACCEPT;
            r.accept_value = ($urandom_range(0, 4) == 0);
        end
        else if (roll < 97)
        begin
            r.req_type = nfa_pkg::REQ_ADD_START;
        end
        else
        begin
            r.req_type = nfa_pkg::REQ_ADD_ALL;
        end
        return r;
    endfunction

    // Offers one beat, with a random gap at the start of each burst, and waits for it to go in.
    task automatic send_req(input nfa_pkg::req_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(0, 2);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        advance_automaton(item);
    endtask

    // Holds the sender off until every queued verdict has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    task automatic test_directed_corners();
        send_req(mk_req(nfa_pkg::REQ_EMPTY_CHECK, 31, 31, 127, 1'b1, 1'b1));
        send_req(mk_req(nfa_pkg::REQ_SYMBOL, 0, 0, 0, 1'b0, 1'b1));
        send_req(mk_req(nfa_pkg::REQ_SET_ACCEPT, 0, 0, 0, 1'b1, 1'b0));
        send_req(mk_req(nfa_pkg::REQ_EMPTY_CHECK, 0, 0, 0, 1'b0, 1'b0));
        send_req(mk_req(nfa_pkg::REQ_ADD_TRANS, 0, 31, 127, 1'b0, 1'b0));
        send_req(mk_req(nfa_pkg::REQ_ADD_TRANS, 31, 0, 0, 1'b1, 1'b1));
        send_req(mk_req(nfa_pkg::REQ_SET_ACCEPT, 31, 0, 0, 1'b1, 1'b0));
        send_req(mk_req(nfa_pkg::REQ_SYMBOL, 0, 0, 127, 1'b0, 1'b0));
        send_req(mk_req(nfa_pkg::REQ_SYMBOL, 31, 31, 0, 1'b1, 1'b1));
        send_req(mk_req(nfa_pkg::REQ_SYMBOL, 0, 0, 127, 1'b0, 1'b1));
        // Second start state, then a transition on every symbol out of it.
        send_req(mk_req(nfa_pkg::REQ_ADD_START, 31, 0, 0, 1'b0, 1'b0));
        send_req(mk_req(nfa_pkg::REQ_ADD_ALL, 31, 5, 127, 1'b1, 1'b1));
        send_req(mk_req(nfa_pkg::REQ_SYMBOL, 0, 0, 55, 1'b0, 1'b1));
        // Empty-string check that abandons a run.
        send_req(mk_req(nfa_pkg::REQ_SYMBOL, 0, 0, 127, 1'b0, 1'b0));
        send_req(mk_req(nfa_pkg::REQ_EMPTY_CHECK, 0, 0, 0, 1'b0, 1'b0));
        send_req(mk_req(REQ_SPARE_A, 31, 31, 127, 1'b1, 1'b1));
        send_req(mk_req(REQ_SPARE_B, 0, 0, 0, 1'b0, 1'b1));
        // Table loads in the middle of a string take effect for the rest of it.
        send_req(mk_req(nfa_pkg::REQ_SYMBOL, 0, 0, 127, 1'b0, 1'b0));
        send_req(mk_req(nfa_pkg::REQ_SET_ACCEPT, 5, 0, 0, 1'b1, 1'b0));
        send_req(mk_req(nfa_pkg::REQ_ADD_TRANS, 5, 17, 3, 1'b0, 1'b0));
        send_req(mk_req(nfa_pkg::REQ_SYMBOL, 0, 0, 3, 1'b0, 1'b1));
        send_req(mk_req(nfa_pkg::REQ_SET_ACCEPT, 0, 0, 0, 1'b0, 1'b0));
        send_req(mk_req(nfa_pkg::REQ_SET_ACCEPT, 31, 0, 0, 1'b0, 1'b0));
        send_req(mk_req(nfa_pkg::REQ_EMPTY_CHECK, 0, 0, 0, 1'b0, 1'b0));
    endtask

    // The receiver stalls for a long stretch while short strings keep arriving.
    task automatic test_output_backpressure();
        hold_count++;
        burst_left = 24;
        for (int k = 0; k < 24; k++)
        begin
            send_req(symbol_req($urandom_range(0, 1) == 1));
        end
    endtask

    task automatic test_random_strings();
        nfa_pkg::req_t r;
        int            sent;
        int            len;
        sent = 0;
        while (sent < 1100)
        begin
            repeat ($urandom_range(0, 4))
            begin
                send_req(load_req());
                sent++;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                r = rand_fields();
                r.req_type = nfa_pkg::REQ_EMPTY_CHECK;
                send_req(r);
                sent++;
            end
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
            begin
                send_req(symbol_req(k == len - 1));
                sent++;
            end
            if ($urandom_range(0, 39) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    // Strings cut short by checks, strings with a load or no-op code inside, and fully random beats.
    task automatic test_broken_runs();
        nfa_pkg::req_t r;
        int            roll;
        repeat (40)
        begin
            repeat ($urandom_range(1, 3)) send_req(symbol_req(1'b0));
            roll = $urandom_range(0, 3);
            case (roll)
                0:
                begin
                    r = rand_fields();
                    r.req_type = nfa_pkg::REQ_EMPTY_CHECK;
                    send_req(r);
                end
                1:
                begin
                    send_req(load_req());
                    send_req(symbol_req(1'b1));
                end
                2:
                begin
                    r = rand_fields();
                    r.req_type = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
                    send_req(r);
                    send_req(symbol_req(1'b1));
                end
                default:
                begin
                    repeat (3) send_req(rand_fields());
                end
            endcase
        end
    endtask

    // Receiver: stall patterns that change every so often, plus the long hold on request.
    initial
    begin
        int pat_mode;
        int pat_left;
        int tick;
        int hold_seen;
        pat_mode  = 0;
        pat_left  = 0;
        tick      = 0;
        hold_seen = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_count != hold_seen)
            begin
                hold_seen = hold_count;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat_mode = $urandom_range(0, 3);
                    pat_left = $urandom_range(20, 200);
                end
                pat_left--;
                case (pat_mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 1) == 1);
                    2: rsp_stall <= ($urandom_range(0, 9) < 8);
                    default: rsp_stall <= (tick % 5 < 2);
                endcase
            end
        end
    end

    // Result checker: every accepted beat is matched against the oldest verdict.
    initial
    begin
        nfa_pkg::rsp_t exp_v;
        verdict_idx = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    flag_error($sformatf("result %0d: no verdict expected (accepted %b any %b)",
                                         verdict_idx, rsp.accepted, rsp.any_active));
                end
                else
                begin
                    exp_v = pending_verdicts.pop_front();
                    if (rsp.accepted !== exp_v.accepted)
                    begin
                        flag_error($sformatf("result %0d: accepted expected %b got %b",
                                             verdict_idx, exp_v.accepted, rsp.accepted));
                    end
                    if (rsp.any_active !== exp_v.any_active)
                    begin
                        flag_error($sformatf("result %0d: any_active expected %b got %b",
                                             verdict_idx, exp_v.any_active, rsp.any_active));
                    end
                end
                verdict_idx++;
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles, %0d verdicts pending",
                         idle_cycles, pending_verdicts.size());
                $display("tb_nfa_set_simulator: errors");
                $finish;
            end
        end
    end

    initial
    begin
        err_count    = 0;
        burst_left   = 0;
        hold_count   = 0;
        accepting    = '0;
        start_states = {{(N_ST-1){1'b0}}, 1'b1};
        live_states  = '0;
        mid_string   = 1'b0;
        foreach (row_sets[i])
        begin
            row_sets[i] = '0;
        end
        sym_pool[0] = '0;
        sym_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++)
        begin
            sym_pool[k] = nfa_pkg::SYMBOL_FW'($urandom_range(0, N_SYM-1));
        end
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        wait_drained();
        test_output_backpressure();
        wait_drained();
        test_random_strings();
        wait_drained();
        test_broken_runs();
        wait_drained();

        // Let a trailing table sweep finish and catch any stray result.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_verdicts.size() == 0)
        begin
            $display("tb_nfa_set_simulator: clean");
        end
        else
        begin
            $display("tb_nfa_set_simulator: errors");
        end
        $finish;
    end

endmodule

>>> files.f
design/nfa_pkg.sv
design/nfa_trans_mem.sv
design/nfa_engine.sv
design/nfa_set_simulator.sv
design/nfa_checker.sv
dv/tb_nfa_set_simulator.sv
